// ----- hw/rtl/dsi_pkg.sv -----
// ----------------------------------------------------------------------------
// dsi_pkg - shared types and constants of the decimal string parser
// Character codes, parse phases, sign and status codes, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package dsi_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;   // first of the control whitespace run
    localparam logic [7:0] CH_CR    = 8'd13;  // last of the control whitespace run
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // Configuration register indexes
    localparam logic CFG_SIGNED_MODE  = 1'b0;
    localparam logic CFG_RESULT_WIDTH = 1'b1;

    // Result width codes (code three behaves as 32 bits)
    localparam logic [1:0] W_8  = 2'd0;
    localparam logic [1:0] W_16 = 2'd1;
    localparam logic [1:0] W_32 = 2'd2;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_SPACE  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_IGNORE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        SG_NONE  = 2'd0,
        SG_PLUS  = 2'd1,
        SG_MINUS = 2'd2
    } t_sign;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_BAD = 2'd1,
        ST_OVF = 2'd2
    } t_status;

    // What a character step produces
    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_BAD  = 2'd1,
        EV_OVF  = 2'd2,
        EV_FIN  = 2'd3
    } t_event;

endpackage

`default_nettype wire

// ----- hw/rtl/decimal_string_to_integer.sv -----
// ----------------------------------------------------------------------------
// decimal_string_to_integer - streaming decimal text to integer parser
// Parses one character per transfer, emits one result per string.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                   | Dir | Transfer when
//  ---------+-------------------------------------------+-----+---------------------
//  char in  | i_valid, o_ready, i_char_code             | in  | i_valid & o_ready
//  result   | o_valid, i_ready, o_value, o_status,      | out | o_valid & i_ready
//           | o_consumed                                |     |
//  config   | i_cfg_we, i_cfg_index, i_cfg_data         | in  | i_cfg_we
//
//  One character per cycle sustained while results are taken. A character
//  waits in the input register; the step logic (multiply by ten, add, range
//  checks) then updates the parse state and, where a result arises, loads
//  the result register, which drives o_valid until the result transfers.
//  Reset is synchronous, active low: parse state cleared, signed mode on,
//  32 bit width. If the result register is full and not taken, the input
//  register holds its character and o_ready drops; otherwise characters flow.
//
`default_nettype none

module decimal_string_to_integer #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // character channel
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_char_code,
    // result channel
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_value,
    output logic [1:0]  o_status,
    output logic [15:0] o_consumed,
    // configuration
    input  wire         i_cfg_we,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [1:0]  i_cfg_data
);
    import dsi_pkg::*;

    // configuration registers
    logic       r_signed_mode;
    logic [1:0] r_result_width;

    // input register
    logic       r_in_valid;
    logic [7:0] r_char;

    // parse state
    t_phase                 r_phase, n_phase;
    t_sign                  r_sign,  n_sign;
    logic [31:0]            r_acc,   n_acc;
    logic [COUNT_WIDTH-1:0] r_dc,    n_dc;
    logic [COUNT_WIDTH-1:0] r_sc,    n_sc;
    t_event                 w_event;

    // result register
    logic        r_out_valid;
    logic [31:0] r_value,    n_value;
    t_status     r_status,   n_status;
    logic [15:0] r_consumed, n_consumed;

    logic w_step;

    // The step fires when a character is held and the result register is free or being taken
    assign w_step  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_step;

    // ---------------- character classes ----------------
    logic        w_zero, w_digit, w_space, w_plus, w_minus, w_pm;
    logic [3:0]  w_dval;
    logic [7:0]  w_dsub;
    logic [35:0] w_x10;
    logic [35:0] w_accsum;
    logic        w_accovf;

    assign w_zero  = (r_char == CH_NUL);
    assign w_digit = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign w_space = (r_char == CH_SPACE) || ((r_char >= CH_TAB) && (r_char <= CH_CR));
    assign w_plus  = (r_char == CH_PLUS);
    assign w_minus = (r_char == CH_MINUS);
    assign w_pm    = w_plus || w_minus;
    assign w_dsub  = r_char - CH_ZERO;
    assign w_dval  = w_dsub[3:0];

    // acc*10 + d; anything above 32 bits is an accumulation overflow
    assign w_x10    = 36'({r_acc, 3'b000}) + 36'({r_acc, 1'b0});
    assign w_accsum = w_x10 + 36'(w_dval);
    assign w_accovf = |w_accsum[35:32];

    // ---------------- next state ----------------
    always_comb begin
        logic to_digits;
        to_digits = 1'b0;
        n_phase = r_phase;
        n_sign  = r_sign;
        n_acc   = r_acc;
        n_dc    = r_dc;
        n_sc    = r_sc;
        w_event = EV_NONE;

        case (r_phase)
            PH_IGNORE: begin
                if (w_zero) begin
                    n_phase = PH_START;
                    n_sign  = SG_NONE;
                    n_acc   = '0;
                    n_dc    = '0;
                    n_sc    = '0;
                end
            end
            PH_START, PH_SPACE: begin
                if (r_phase == PH_START && r_signed_mode && w_pm) begin
                    // leading sign, whitespace may follow
                    n_sign  = w_minus ? SG_MINUS : SG_PLUS;
                    n_phase = PH_SPACE;
                end else if (w_space) begin
                    n_sc    = (r_sc == '1) ? r_sc : r_sc + 1'b1;
                    n_phase = PH_SPACE;
                end else if (r_signed_mode && r_sign == SG_NONE && w_pm) begin
                    n_sign  = w_minus ? SG_MINUS : SG_PLUS;
                    n_phase = PH_DIGITS;
                end else if (!r_signed_mode && w_plus) begin
                    // unsigned plus counts as skipped
                    n_sc    = (r_sc == '1) ? r_sc : r_sc + 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    to_digits = 1'b1;
                end
            end
            PH_DIGITS: begin
                to_digits = 1'b1;
            end
            default: begin
                to_digits = 1'b0;
            end
        endcase

        if (to_digits) begin
            if (w_zero) begin
                w_event = (r_dc == '0) ? EV_BAD : EV_FIN;
                n_phase = PH_START;
                n_sign  = SG_NONE;
                n_acc   = '0;
                n_dc    = '0;
                n_sc    = '0;
            end else if (w_digit) begin
                if (w_accovf) begin
                    w_event = EV_OVF;
                    n_phase = PH_IGNORE;
                end else begin
                    n_acc   = w_accsum[31:0];
                    n_dc    = (r_dc == '1) ? r_dc : r_dc + 1'b1;
                    n_phase = PH_DIGITS;
                end
            end else begin
                // early stop only with digits and a sign in signed mode
                n_phase = PH_IGNORE;
                w_event = (r_signed_mode && r_dc != '0 && r_sign != SG_NONE) ? EV_FIN
                                                                             : EV_BAD;
            end
        end
    end

    // ---------------- result ----------------
    logic                   w_neg, w_rng_ovf, w_wid_ovf;
    logic [31:0]            w_sval;
    logic [COUNT_WIDTH:0]   w_cnt_sum;
    logic [COUNT_WIDTH-1:0] w_cnt_sat;
    logic [32:0]            w_cnt_ext;
    logic [15:0]            w_cnt;

    assign w_neg     = (r_sign == SG_MINUS);
    assign w_rng_ovf = r_signed_mode &&
                       ((!w_neg && r_acc[31]) || (w_neg && r_acc > 32'h8000_0000));
    assign w_sval    = (r_signed_mode && w_neg) ? (32'd0 - r_acc) : r_acc;

    always_comb begin
        w_wid_ovf = 1'b0;
        case (r_result_width)
            W_8: begin
                if (r_signed_mode) begin
                    w_wid_ovf = !((w_sval[31:7] == '0) || (w_sval[31:7] == '1));
                end else begin
                    w_wid_ovf = (w_sval[31:8] != '0);
                end
            end
            W_16: begin
                if (r_signed_mode) begin
                    w_wid_ovf = !((w_sval[31:15] == '0) || (w_sval[31:15] == '1));
                end else begin
                    w_wid_ovf = (w_sval[31:16] != '0);
                end
            end
            default: begin
                w_wid_ovf = 1'b0;
            end
        endcase
    end

    // digits + skipped + sign, saturated at the counter max and at 16 bits
    assign w_cnt_sum = {1'b0, r_dc} + {1'b0, r_sc} +
                       (COUNT_WIDTH+1)'(r_signed_mode && r_sign != SG_NONE);
    assign w_cnt_sat = w_cnt_sum[COUNT_WIDTH] ? '1 : w_cnt_sum[COUNT_WIDTH-1:0];
    assign w_cnt_ext = 33'(w_cnt_sat);
    assign w_cnt     = (w_cnt_ext > 33'd65535) ? 16'hFFFF : w_cnt_ext[15:0];

    always_comb begin
        n_value    = '0;
        n_status   = ST_OK;
        n_consumed = '0;
        case (w_event)
            EV_BAD: begin
                n_status = ST_BAD;
            end
            EV_OVF: begin
                n_status = ST_OVF;
            end
            EV_FIN: begin
                if (w_rng_ovf || w_wid_ovf) begin
                    n_status = ST_OVF;
                end else begin
                    n_value    = w_sval;
                    n_consumed = w_cnt;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode  <= 1'b1;
            r_result_width <= W_32;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SIGNED_MODE:  r_signed_mode  <= i_cfg_data[0];
                CFG_RESULT_WIDTH: r_result_width <= i_cfg_data;
                default:          r_signed_mode  <= r_signed_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_sign  <= SG_NONE;
            r_acc   <= '0;
            r_dc    <= '0;
            r_sc    <= '0;
        end else if (w_step) begin
            r_phase <= n_phase;
            r_sign  <= n_sign;
            r_acc   <= n_acc;
            r_dc    <= n_dc;
            r_sc    <= n_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_event != EV_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_event != EV_NONE) begin
            r_value    <= n_value;
            r_status   <= n_status;
            r_consumed <= n_consumed;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_value    = r_value;
    assign o_status   = r_status;
    assign o_consumed = r_consumed;

endmodule

`default_nettype wire

// ----- sim/decimal_string_to_integer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_string_to_integer_tb - self-checking bench for the decimal parser
// Streams character strings into the parser under random idling, with long
// result stalls to force back-pressure, and works out every parsed integer
// in a cycle-free model of its own. Each result transfer is compared field
// by field with the oldest pending parse. Both register settings are swept
// between runs of strings, with long blank and zero runs sent once.
// ----------------------------------------------------------------------------

module decimal_string_to_integer_tb;

    import dsi_pkg::*;

    localparam logic [31:0] ACC_LIMIT = 32'd429496729;   // largest value safe to scale by ten
    localparam logic [31:0] I32_MAX   = 32'h7FFF_FFFF;
    localparam int unsigned LONG_HOLD = 120;             // result stall that backs up the input
    localparam int unsigned LONG_RUN  = 200;             // length of the gapless blank/zero runs

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
        logic [15:0] consumed;
    } t_parse_result;

    // DUT ports; the inputs are at known values from time zero
    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [7:0]  i_char_code = CH_NUL;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [31:0] o_value;
    logic [1:0]  o_status;
    logic [15:0] o_consumed;
    logic        i_cfg_we    = 1'b0;
    logic [0:0]  i_cfg_index = CFG_SIGNED_MODE;
    logic [1:0]  i_cfg_data  = 2'd0;

    // Bench copy of the registers and the parse state
    logic        cfg_signed = 1'b1;
    logic [1:0]  cfg_width  = W_32;
    t_phase      ph         = PH_START;
    t_sign       sg         = SG_NONE;
    logic [31:0] acc        = 32'd0;
    logic [15:0] ndig       = 16'd0;
    logic [15:0] nskip      = 16'd0;

    logic [7:0]    pending_chars[$];       // characters not yet offered
    t_parse_result parse_results_due[$];   // parsed integers still to come out

    bit          idle_on = 1'b1;           // random gaps on both sides
    int unsigned send_wait;
    int unsigned take_wait;
    int unsigned hold_left;
    int unsigned results_taken;
    int unsigned fail_count;

    // Range boundaries of the three widths and of the accumulator
    longint unsigned limit_values[8] = '{
        64'd128, 64'd256, 64'd32768, 64'd65536,
        64'd2147483648, 64'd4294967296, 64'd429496730, 64'd4294967290
    };

    decimal_string_to_integer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_value     (o_value),
        .o_status    (o_status),
        .o_consumed  (o_consumed),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Parse model
    // ------------------------------------------------------------------------

    function automatic logic [15:0] bump(logic [15:0] n);
        return (n == 16'hFFFF) ? n : n + 16'd1;
    endfunction

    function automatic t_parse_result no_number(t_status st);
        t_parse_result r;
        r.value    = 32'd0;
        r.status   = st;
        r.consumed = 16'd0;
        return r;
    endfunction

    function automatic void clear_parse();
        ph    = PH_START;
        sg    = SG_NONE;
        acc   = 32'd0;
        ndig  = 16'd0;
        nskip = 16'd0;
    endfunction

    // Range checks once at least one digit is in: signed range first, then
    // the selected width (code three acts as 32 bits)
    function automatic t_parse_result finish_value();
        logic [31:0]   v;
        logic [17:0]   cnt;
        t_parse_result r;
        if (cfg_signed) begin
            if ((sg != SG_MINUS && acc > I32_MAX) || (sg == SG_MINUS && acc > I32_MAX + 32'd1))
                return no_number(ST_OVF);
            v = (sg == SG_MINUS) ? 32'd0 - acc : acc;
            if (cfg_width == W_8 && !(v <= 32'd127 || v >= 32'hFFFF_FF80))
                return no_number(ST_OVF);
            if (cfg_width == W_16 && !(v <= 32'd32767 || v >= 32'hFFFF_8000))
                return no_number(ST_OVF);
        end else begin
            v = acc;
            if ((cfg_width == W_8 && v > 32'd255) || (cfg_width == W_16 && v > 32'd65535))
                return no_number(ST_OVF);
        end
        cnt = 18'(ndig) + 18'(nskip) + 18'(cfg_signed && sg != SG_NONE);
        r.value    = v;
        r.status   = ST_OK;
        r.consumed = (cnt > 18'h0FFFF) ? 16'hFFFF : cnt[15:0];
        return r;
    endfunction

    // One accepted character; queues the parse result it produces, if any
    task automatic parse_char(logic [7:0] c);
        logic [31:0] m;
        logic [32:0] sum;
        if (ph == PH_IGNORE) begin
            if (c == CH_NUL)
                clear_parse();
            return;
        end
        // a sign may lead, before any whitespace
        if (ph == PH_START) begin
            ph = PH_SPACE;
            if (cfg_signed && (c == CH_MINUS || c == CH_PLUS)) begin
                sg = (c == CH_MINUS) ? SG_MINUS : SG_PLUS;
                return;
            end
        end
        if (ph == PH_SPACE) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                nskip = bump(nskip);
                return;
            end
            ph = PH_DIGITS;
            if (cfg_signed) begin
                if (sg == SG_NONE && (c == CH_MINUS || c == CH_PLUS)) begin
                    sg = (c == CH_MINUS) ? SG_MINUS : SG_PLUS;
                    return;
                end
            end else if (c == CH_PLUS) begin
                nskip = bump(nskip);   // unsigned plus counts as skipped
                return;
            end
        end
        if (c == CH_NUL) begin
            if (ndig == 16'd0)
                parse_results_due.push_back(no_number(ST_BAD));
            else
                parse_results_due.push_back(finish_value());
            clear_parse();
            return;
        end
        if (c >= CH_ZERO && c <= CH_NINE) begin
            m   = acc * 32'd10;
            sum = {1'b0, m} + 33'(c - CH_ZERO);
            if (acc > ACC_LIMIT || sum[32]) begin
                ph = PH_IGNORE;
                parse_results_due.push_back(no_number(ST_OVF));
                return;
            end
            acc  = sum[31:0];
            ndig = bump(ndig);
            return;
        end
        // non-digit: early stop only with digits and a sign in signed mode
        ph = PH_IGNORE;
        if (cfg_signed && ndig != 16'd0 && sg != SG_NONE)
            parse_results_due.push_back(finish_value());
        else
            parse_results_due.push_back(no_number(ST_BAD));
    endtask

    // ------------------------------------------------------------------------
    // Character side: one offer at a time, random gap drawn per item
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            send_wait <= 0;
        end else begin
            if (i_valid && o_ready)
                parse_char(i_char_code);
            // the slot is free when nothing is on offer or the offer just went
            if (!i_valid || o_ready) begin
                if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    i_valid   <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    i_char_code <= pending_chars.pop_front();
                    i_valid     <= 1'b1;
                    send_wait   <= idle_on ? $urandom_range(0, 14) : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side: compare each transfer, random stall per result, and now
    // and then a long hold so the parser backs up and drops o_ready
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_side
        int unsigned   w;
        int unsigned   h;
        t_parse_result want;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            take_wait <= 0;
            hold_left <= 0;
        end else begin
            w = take_wait;
            h = hold_left;
            if (h != 0)
                h = h - 1;
            if (o_valid && i_ready) begin
                if (parse_results_due.size() == 0) begin
                    $error("unexpected result: value %h status %0d consumed %0d",
                           o_value, o_status, o_consumed);
                    fail_count++;
                end else begin
                    want = parse_results_due.pop_front();
                    if (o_value !== want.value) begin
                        $error("value: expected %h, got %h", want.value, o_value);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_consumed !== want.consumed) begin
                        $error("consumed: expected %0d, got %0d", want.consumed, o_consumed);
                        fail_count++;
                    end
                end
                if (results_taken % 300 == 150)
                    h = LONG_HOLD;
                results_taken++;
                w = idle_on ? $urandom_range(0, 14) : 0;
            end else if (w != 0) begin
                w = w - 1;
            end
            take_wait <= w;
            hold_left <= h;
            i_ready   <= (w == 0) && (h == 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Wait for the parser to go quiet: nothing queued, nothing on offer, no
    // result owed, then let a last character that yields no result pass through
    task automatic drain();
        do @(negedge i_clk);
        while (pending_chars.size() != 0 || i_valid || parse_results_due.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        if (idx == CFG_SIGNED_MODE)
            cfg_signed = data[0];
        else
            cfg_width = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_text(string s);
        foreach (s[i])
            pending_chars.push_back(s[i]);
        pending_chars.push_back(CH_NUL);
    endtask

    function automatic logic [7:0] pick_blank();
        int unsigned r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] pick_sign();
        return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
    endfunction

    // Decimal digits of n, sometimes with leading zeros
    task automatic queue_number(longint unsigned n);
        logic [7:0] digs[$];
        do begin
            digs.push_front(CH_ZERO + 8'(n % 10));
            n = n / 10;
        end while (n != 0);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 2)) pending_chars.push_back(CH_ZERO);
        foreach (digs[i])
            pending_chars.push_back(digs[i]);
    endtask

    // Mostly well-formed numbers, some near the range limits, some long digit
    // runs that may overflow, the rest random bytes
    task automatic queue_string();
        int unsigned     kind;
        longint unsigned n;
        logic [7:0]      c;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            if ($urandom_range(0, 2) == 0)
                pending_chars.push_back(pick_sign());
            if ($urandom_range(0, 1))
                repeat ($urandom_range(1, 3)) pending_chars.push_back(pick_blank());
            if ($urandom_range(0, 9) < 3)
                pending_chars.push_back(pick_sign());
            case ($urandom_range(0, 3))
                0:       n = $urandom_range(0, 400);
                1:       n = limit_values[$urandom_range(0, 7)] - 1 + $urandom_range(0, 2);
                2:       n = $urandom();
                default: n = {$urandom(), $urandom()} % 64'd100000000000;
            endcase
            queue_number(n);
            if ($urandom_range(0, 3) == 0) begin
                do c = 8'($urandom_range(1, 255));
                while (c >= CH_ZERO && c <= CH_NINE);
                pending_chars.push_back(c);
                repeat ($urandom_range(0, 3)) pending_chars.push_back(8'($urandom_range(1, 255)));
            end
        end else if (kind < 85) begin
            repeat ($urandom_range(9, 12))
                pending_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end else begin
            repeat ($urandom_range(1, 8)) pending_chars.push_back(8'($urandom_range(0, 255)));
        end
        pending_chars.push_back(CH_NUL);
    endtask

    initial begin
        int unsigned queued;
        int unsigned sz;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings at reset settings (signed, 32 bits)
        queue_text("+7x");           // early stop after a sign and a digit
        queue_text("\t-0");          // sign after whitespace
        queue_text("5a");            // non-digit without a sign
        queue_text("-");             // sign but no digits
        queue_text("");              // bare terminator
        queue_text("4294967296");    // accumulator overflow on the last digit
        pending_chars.push_back(8'hFF);
        pending_chars.push_back(CH_NUL);
        drain();

        // Long blank and zero runs without gaps
        idle_on = 1'b0;
        pending_chars.push_back(CH_PLUS);
        repeat (LONG_RUN) pending_chars.push_back(CH_SPACE);
        queue_text("42");
        drain();
        write_reg(CFG_SIGNED_MODE, 2'b00);
        pending_chars.push_back(CH_PLUS);
        repeat (LONG_RUN) pending_chars.push_back(CH_ZERO);
        queue_text("9");

        // Random strings over every mode and width, idling off every third run
        for (int k = 0; k < 12; k++) begin
            drain();
            write_reg(CFG_SIGNED_MODE, {1'($urandom_range(0, 1)), 1'(k % 2)});
            write_reg(CFG_RESULT_WIDTH, 2'((k / 2) % 4));
            idle_on = (k % 3) != 2;
            queued  = 0;
            while (queued < 100) begin
                sz = pending_chars.size();
                queue_string();
                queued += pending_chars.size() - sz;
            end
        end
        drain();

        if (fail_count == 0 && parse_results_due.size() == 0)
            $display("decimal_string_to_integer test passed");
        else
            $display("decimal_string_to_integer test failed");
        $finish;
    end

    // Hang guard
    initial begin
        #10_000_000;
        $display("decimal_string_to_integer test failed");
        $finish;
    end

endmodule
